@@ hw/rtl/imu_fp_pkg.sv @@
// Shared types, constants and scaling helpers for the IMU frame parser.
`default_nettype none
package imu_fp_pkg;

  // Frame bytes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Frame kinds as reported on the result channel
  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  // Scale factors: rate is raw*125>>7, angle is raw*45>>9
  localparam logic [8:0] RATE_MUL    = 9'd125;
  localparam logic [8:0] ANGLE_MUL   = 9'd45;
  localparam int         RATE_SHIFT  = 7;
  localparam int         ANGLE_SHIFT = 9;
  localparam int         FILT_SHIFT  = 8;
  localparam logic [8:0] K_FULL      = 9'd256;

  localparam int PAY_BYTES = 8;
  localparam int ACC_W     = 26;

  // Receive framing phase; the unused code behaves as hunting
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Result sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_ROLL  = 3'd1,
    S_PITCH = 3'd2,
    S_YAW   = 3'd3,
    S_MIXA  = 3'd4,
    S_MIXB  = 3'd5,
    S_DONE  = 3'd6
  } seq_t;

  // Framer status toward the sequencer
  typedef struct packed {
    logic frame_ok;  // checksum byte transferred and matched
    logic kind;      // kind of the frame held in the payload store
  } rx_stat_t;

  // Raw little-endian payload words
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } rx_words_t;

  // One command to the shared multiply-accumulate unit
  typedef struct packed {
    logic               en;
    logic               clr;
    logic signed [15:0] a;
    logic [8:0]         b;
  } mac_op_t;

  // Floor-shift a product down to a 16-bit value for the given frame kind
  function automatic logic signed [15:0] imu_scale(input logic signed [ACC_W-1:0] p,
                                                   input logic kind);
    logic signed [ACC_W-1:0] s;
    s = (kind == KIND_ANGLE) ? (p >>> ANGLE_SHIFT) : (p >>> RATE_SHIFT);
    return s[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/imu_fp_if.sv @@
// Valid/ready channel interfaces for received bytes and parsed results.
`default_nettype none
interface imu_fp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_fp_out_if;
  logic               valid;
  logic               ready;
  logic               frame_kind;
  logic signed [15:0] pitch_value;
  logic signed [15:0] roll_value;
  logic signed [15:0] yaw_value;

  modport source (output valid, output frame_kind, output pitch_value, output roll_value,
                  output yaw_value, input ready);
  modport sink   (input valid, input frame_kind, input pitch_value, input roll_value,
                  input yaw_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/imu_fp_mac.sv @@
// Shared signed multiply-accumulate unit, one operation per cycle.
`default_nettype none
module imu_fp_mac (
  input  wire logic                             clk,
  input  wire imu_fp_pkg::mac_op_t              op,
  output logic signed [imu_fp_pkg::ACC_W-1:0]   acc
);
  import imu_fp_pkg::*;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] prod;

  // Multiply signed operand by unsigned weight
  assign prod = ACC_W'(op.a) * ACC_W'($signed({1'b0, op.b}));

  // Clear or accumulate
  always_comb begin
    acc_nxt = op.clr ? prod : ACC_W'(acc_r + prod);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

@@ hw/rtl/imu_fp_rx.sv @@
// Byte framer: header hunt, type decode, payload store and checksum.
`default_nettype none
module imu_fp_rx (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_xfer,
  input  wire logic [7:0]            rx_byte,
  output imu_fp_pkg::rx_stat_t       stat,
  output imu_fp_pkg::rx_words_t      words
);
  import imu_fp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       kind_r, kind_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pay_r [PAY_BYTES];
  logic       pay_we;
  logic       frame_ok;

  // Decode one transferred byte
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    pay_we    = 1'b0;
    frame_ok  = 1'b0;
    if (byte_xfer) begin
      unique case (phase_r)
        PH_TYPE: begin
          if (rx_byte == TYPE_RATE || rx_byte == TYPE_ANGLE) begin
            kind_nxt  = (rx_byte == TYPE_ANGLE) ? KIND_ANGLE : KIND_RATE;
            sum_nxt   = 8'(sum_r + rx_byte);
            idx_nxt   = 4'd0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (!idx_r[3]) begin
            pay_we  = 1'b1;
            sum_nxt = 8'(sum_r + rx_byte);
            idx_nxt = 4'(idx_r + 4'd1);
          end else begin
            phase_nxt = PH_HUNT;
            idx_nxt   = 4'd0;
            frame_ok  = (rx_byte == sum_r);
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == HDR_BYTE) begin
            sum_nxt   = HDR_BYTE;
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      kind_r  <= KIND_RATE;
      idx_r   <= 4'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Payload store
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_r[idx_r[2:0]] <= rx_byte;
    end
  end

  assign stat.frame_ok = frame_ok;
  assign stat.kind     = kind_r;
  assign words.roll    = {pay_r[1], pay_r[0]};
  assign words.pitch   = {pay_r[3], pay_r[2]};
  assign words.yaw     = {pay_r[5], pay_r[4]};

endmodule
`default_nettype wire

@@ hw/rtl/imu_frame_parser_unit.sv @@
// Top level: framer, multiply-accumulate sequencer, yaw-rate filter and result register.
// Bytes are accepted while the sequencer is idle; after the checksum byte of a good frame the
// sequencer steps through roll, pitch and yaw (then MIXA and MIXB for a rate frame) on the
// single shared multiply-accumulate unit before it loads the result register.
// Throughput: one byte per cycle while idle; ready drops while a good frame is sequenced, more if out stalls.
// Reset (rst_n low, synchronous) returns to header hunt, clears filter weight and state.
`default_nettype none
module imu_frame_parser_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  imu_fp_in_if.sink       in_ch,
  imu_fp_out_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);
  import imu_fp_pkg::*;

  rx_stat_t                stat;
  rx_words_t               words;
  mac_op_t                 op;
  logic signed [ACC_W-1:0] acc;
  logic                    byte_xfer;

  seq_t                    seq_r, seq_nxt;
  logic [8:0]              filter_k_r;
  logic [8:0]              k_sat;
  logic signed [15:0]      roll_cap_r;
  logic signed [15:0]      pitch_cap_r;
  logic signed [15:0]      yf_r;
  logic signed [15:0]      mix_val;
  logic signed [15:0]      yaw_res;
  logic [8:0]              coef;
  logic                    cap_roll;
  logic                    cap_pitch;
  logic                    load_out;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r;
  logic signed [15:0]      out_pitch_r;
  logic signed [15:0]      out_roll_r;
  logic signed [15:0]      out_yaw_r;

  // Framer
  assign in_ch.ready = (seq_r == S_IDLE);
  assign byte_xfer   = in_ch.valid && in_ch.ready;

  imu_fp_rx u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_xfer (byte_xfer),
    .rx_byte   (in_ch.rx_byte),
    .stat      (stat),
    .words     (words)
  );

  // Shared multiply-accumulate unit
  imu_fp_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_k_r <= 9'd0;
    end else if (cfg_we) begin
      filter_k_r <= cfg_wdata;
    end
  end

  assign k_sat = (filter_k_r > K_FULL) ? K_FULL : filter_k_r;
  assign coef  = (stat.kind == KIND_ANGLE) ? ANGLE_MUL : RATE_MUL;

  // Filtered yaw is the floor of the accumulated mix over 256
  always_comb begin
    logic signed [ACC_W-1:0] mix_sh;
    mix_sh  = acc >>> FILT_SHIFT;
    mix_val = mix_sh[15:0];
  end

  assign yaw_res  = (stat.kind == KIND_ANGLE) ? imu_scale(acc, KIND_ANGLE) : mix_val;
  assign load_out = (seq_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      S_IDLE:  if (stat.frame_ok) seq_nxt = S_ROLL;
      S_ROLL:  seq_nxt = S_PITCH;
      S_PITCH: seq_nxt = S_YAW;
      S_YAW:   seq_nxt = (stat.kind == KIND_ANGLE) ? S_DONE : S_MIXA;
      S_MIXA:  seq_nxt = S_MIXB;
      S_MIXB:  seq_nxt = S_DONE;
      S_DONE:  if (load_out) seq_nxt = S_IDLE;
      default: seq_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: unit command and capture strobes
  always_comb begin
    op        = '0;
    cap_roll  = 1'b0;
    cap_pitch = 1'b0;
    unique case (seq_r)
      S_ROLL: begin
        op = '{en: 1'b1, clr: 1'b1, a: words.roll, b: coef};
      end
      S_PITCH: begin
        cap_roll = 1'b1;
        op       = '{en: 1'b1, clr: 1'b1, a: words.pitch, b: coef};
      end
      S_YAW: begin
        cap_pitch = 1'b1;
        op        = '{en: 1'b1, clr: 1'b1, a: words.yaw, b: coef};
      end
      S_MIXA: begin
        op = '{en: 1'b1, clr: 1'b1, a: imu_scale(acc, KIND_RATE),
               b: 9'(K_FULL - k_sat)};
      end
      S_MIXB: begin
        op = '{en: 1'b1, clr: 1'b0, a: yf_r, b: k_sat};
      end
      default: begin
        op = '0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= S_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  // Hold scaled roll and pitch until the frame is done
  always_ff @(posedge clk) begin
    if (cap_roll) begin
      roll_cap_r <= imu_scale(acc, stat.kind);
    end
    if (cap_pitch) begin
      pitch_cap_r <= imu_scale(acc, stat.kind);
    end
  end

  // Advance filtered yaw rate only when a rate result is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yf_r <= 16'sd0;
    end else if (load_out && stat.kind == KIND_RATE) begin
      yf_r <= mix_val;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r  <= stat.kind;
      out_pitch_r <= pitch_cap_r;
      out_roll_r  <= roll_cap_r;
      out_yaw_r   <= yaw_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_kind  = out_kind_r;
  assign out_ch.pitch_value = out_pitch_r;
  assign out_ch.roll_value  = out_roll_r;
  assign out_ch.yaw_value   = out_yaw_r;

  // A good checksum always starts the sequence
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_IDLE && stat.frame_ok) |=> (seq_r == S_ROLL))
    else $error("good frame did not start the sequencer");

  // A result appears only out of the final sequencer step
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(seq_r) == S_DONE))
    else $error("result valid rose outside the final step");

  // A pending rate result carries the stored filter value
  a_filt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_RATE) |-> (out_yaw_r == yf_r))
    else $error("rate yaw differs from filter state");

endmodule
`default_nettype wire

@@ verif/imu_fp_checker.sv @@
// Checker for the IMU frame parser: tracks filter weight and frames, compares every result.
`timescale 1ns / 100ps
module imu_fp_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  imu_fp_in_if            in_mon,
  imu_fp_out_if           out_mon,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata,
  output int              n_waiting,
  output int              n_errors
);
  import imu_fp_pkg::*;

  localparam int RATE_GAIN   = 125;
  localparam int RATE_DROP   = 7;
  localparam int ANGLE_GAIN  = 45;
  localparam int ANGLE_DROP  = 9;
  localparam int WEIGHT_FULL = 256;

  typedef struct packed {
    logic        kind;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] yaw;
  } frame_res_t;

  // Parser state as the block should hold it
  phase_t      rx_phase;
  logic        rx_kind;
  int          rx_idx;
  logic [7:0]  rx_bytes [PAY_BYTES];
  logic [7:0]  rx_sum;
  int          yaw_rate_q;
  logic [8:0]  filt_k;
  frame_res_t  due_q [$];
  frame_res_t  seen_res;
  frame_res_t  want_res;
  int          err_total = 0;

  // Signed little-endian word from the payload store
  function automatic int raw_word(input int lo);
    logic signed [15:0] w;
    w = {rx_bytes[lo + 1], rx_bytes[lo]};
    return w;
  endfunction

  // Advance the framer by one byte and queue any finished frame
  task automatic parse_byte(input logic [7:0] b);
    int k_eff;
    int fresh;
    int mix;
    frame_res_t res;
    case (rx_phase)
      PH_TYPE: begin
        if (b == TYPE_RATE || b == TYPE_ANGLE) begin
          rx_kind  = (b == TYPE_ANGLE) ? KIND_ANGLE : KIND_RATE;
          rx_sum   = rx_sum + b;
          rx_idx   = 0;
          rx_phase = PH_DATA;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx_idx < PAY_BYTES) begin
          rx_bytes[rx_idx] = b;
          rx_sum = rx_sum + b;
          rx_idx++;
        end else begin
          rx_phase = PH_HUNT;
          rx_idx   = 0;
          // drop the frame on a checksum miss, filter untouched
          if (b == rx_sum) begin
            res.kind = rx_kind;
            if (rx_kind == KIND_RATE) begin
              k_eff      = (filt_k > K_FULL) ? WEIGHT_FULL : int'(filt_k);
              fresh      = (raw_word(4) * RATE_GAIN) >>> RATE_DROP;
              mix        = fresh * (WEIGHT_FULL - k_eff) + yaw_rate_q * k_eff;
              yaw_rate_q = mix >>> 8;
              res.pitch  = 16'((raw_word(2) * RATE_GAIN) >>> RATE_DROP);
              res.roll   = 16'((raw_word(0) * RATE_GAIN) >>> RATE_DROP);
              res.yaw    = 16'(yaw_rate_q);
            end else begin
              res.pitch = 16'((raw_word(2) * ANGLE_GAIN) >>> ANGLE_DROP);
              res.roll  = 16'((raw_word(0) * ANGLE_GAIN) >>> ANGLE_DROP);
              res.yaw   = 16'((raw_word(4) * ANGLE_GAIN) >>> ANGLE_DROP);
            end
            due_q.push_back(res);
          end
        end
      end
      default: begin
        // hunting, and any stray phase code
        rx_phase = PH_HUNT;
        if (b == HDR_BYTE) begin
          rx_sum   = HDR_BYTE;
          rx_phase = PH_TYPE;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t chk: %s mismatch, expected %h actual %h", $time, name, want, seen);
      err_total++;
    end
  endtask

  // Sample all transfers at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase   = PH_HUNT;
      rx_kind    = KIND_RATE;
      rx_idx     = 0;
      rx_sum     = '0;
      yaw_rate_q = 0;
      filt_k     = '0;
      for (int i = 0; i < PAY_BYTES; i++) rx_bytes[i] = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen_res = {out_mon.frame_kind, out_mon.pitch_value, out_mon.roll_value,
                    out_mon.yaw_value};
        if (due_q.size() == 0) begin
          $display("%0t chk: unexpected result, expected none actual %h", $time, seen_res);
          err_total++;
        end else begin
          want_res = due_q.pop_front();
          compare_field("frame_kind", 16'(want_res.kind), 16'(seen_res.kind));
          compare_field("pitch_value", want_res.pitch, seen_res.pitch);
          compare_field("roll_value", want_res.roll, seen_res.roll);
          compare_field("yaw_value", want_res.yaw, seen_res.yaw);
        end
      end
      if (cfg_we) filt_k = cfg_wdata;
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.rx_byte);
    end
    n_waiting <= due_q.size();
    n_errors  <= err_total;
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the IMU frame parser: clock, reset, byte and frame stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import imu_fp_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 150;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  int         n_waiting;
  int         n_errors;
  int         gap_pct;
  int         stall_pct;
  int         byte_count;
  int         cycle_cnt;
  bit         hold_req;
  bit         hold_off;

  imu_fp_in_if  in_ch ();
  imu_fp_out_if out_ch ();

  imu_frame_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  imu_fp_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .n_waiting (n_waiting),
    .n_errors  (n_errors)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, forced low during a hold-off
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps pushing
  initial begin
    @(posedge hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Offer one byte with random leading gaps, return at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    byte_count++;
    @(negedge clk);
  endtask

  // Build and send a frame; sum_flip corrupts the checksum, hdr_sum forces it to the header
  task automatic send_frame(input logic [7:0] type_b, input logic [15:0] roll,
                            input logic [15:0] pitch, input logic [15:0] yaw,
                            input logic [15:0] temp, input logic [7:0] sum_flip,
                            input bit hdr_sum);
    logic [7:0] fb [11];
    logic [7:0] s;
    fb[0] = HDR_BYTE;
    fb[1] = type_b;
    {fb[3], fb[2]} = roll;
    {fb[5], fb[4]} = pitch;
    {fb[7], fb[6]} = yaw;
    {fb[9], fb[8]} = temp;
    s = '0;
    for (int i = 0; i < 10; i++) s = s + fb[i];
    if (hdr_sum) begin
      fb[8] = fb[8] + (HDR_BYTE - s);
      s = HDR_BYTE;
    end
    fb[10] = s ^ sum_flip;
    for (int i = 0; i < 11; i++) send_byte(fb[i]);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_frame(input bit corrupt);
    logic [7:0] type_b;
    logic [7:0] flip;
    type_b = $urandom_range(0, 1) ? TYPE_ANGLE : TYPE_RATE;
    flip   = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(type_b, pick_word(), pick_word(), pick_word(), pick_word(), flip,
               $urandom_range(0, 19) == 0);
  endtask

  // Hold the sender until every result is in, let the block settle, then write the weight
  task automatic retune_filter(input logic [8:0] k);
    in_ch.valid <= 1'b0;
    while (n_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly clean frames, some corrupted, plus noise and broken sequences
  task automatic run_phase(input int gap, input int stall, input int n_bytes);
    int stop_at;
    int pick;
    logic [7:0] junk;
    gap_pct   = gap;
    stall_pct <= stall;
    stop_at   = byte_count + n_bytes;
    while (byte_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_random_frame(1'b0);
      end else if (pick < 82) begin
        send_random_frame(1'b1);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 95) begin
        // header followed by a type byte that is neither rate nor angle
        do junk = 8'($urandom); while (junk == TYPE_RATE || junk == TYPE_ANGLE);
        send_byte(HDR_BYTE);
        send_byte(junk);
      end else begin
        // truncated frame; the next frame's bytes get eaten as payload
        send_byte(HDR_BYTE);
        send_byte($urandom_range(0, 1) ? TYPE_ANGLE : TYPE_RATE);
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    byte_count    = 0;
    cycle_cnt     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames with the weight at zero
    retune_filter(9'd0);
    send_frame(TYPE_RATE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    send_frame(TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h00, 1'b0);
    send_frame(TYPE_ANGLE, 16'h0000, 16'hFFFF, 16'h0001, 16'h1234, 8'h00, 1'b0);
    // unknown type byte, then a good frame
    send_byte(HDR_BYTE);
    send_byte(8'h54);
    send_frame(TYPE_RATE, 16'h0001, 16'hFFFF, 16'h8000, 16'h0000, 8'h00, 1'b0);
    // header in the type slot is consumed, not taken as a new header
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(TYPE_RATE);
    send_frame(TYPE_ANGLE, 16'h4000, 16'hC000, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    // bad checksum leaves the filter alone
    send_frame(TYPE_RATE, 16'h1111, 16'h2222, 16'h7FFF, 16'h0000, 8'h01, 1'b0);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    // checksum equal to the header byte, then a frame right behind it
    send_frame(TYPE_RATE, 16'h0123, 16'hFEDC, 16'h3000, 16'h0000, 8'h00, 1'b1);
    send_frame(TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 8'h00, 1'b0);

    // Weight above full scale saturates and holds the filtered yaw
    retune_filter(9'd511);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 8'h00, 1'b0);
    retune_filter(9'd256);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 8'h00, 1'b0);
    retune_filter(9'd128);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 8'h00, 1'b0);
    send_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 1'b0);

    // Random phases over the idling mixes and several weights
    retune_filter(9'd0);
    run_phase(0, 0, PHASE_BYTES);
    retune_filter(9'd256);
    run_phase(72, 0, PHASE_BYTES);
    retune_filter(9'($urandom_range(0, 511)));
    run_phase(0, 72, PHASE_BYTES);
    retune_filter(9'd1);
    run_phase(36, 36, PHASE_BYTES);

    // Receiver holds off while the sender keeps offering frames
    retune_filter(9'd255);
    gap_pct   = 0;
    stall_pct <= 0;
    hold_req  = 1'b1;
    repeat (12) send_random_frame(1'b0);

    retune_filter(9'd511);
    run_phase(36, 36, PHASE_BYTES);

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    while (n_waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ imu_frame_parser_unit.f @@
hw/rtl/imu_fp_pkg.sv
hw/rtl/imu_fp_if.sv
hw/rtl/imu_fp_mac.sv
hw/rtl/imu_fp_rx.sv
hw/rtl/imu_frame_parser_unit.sv
verif/imu_fp_checker.sv
verif/tb.sv
